[design/kac_pkg.sv]
// ----------------------------------------------------------------------------
// kac_pkg: shared types and constants of the keypad adding calculator
// Key codes, seven-segment patterns and the result beat that leaves the core.
// ----------------------------------------------------------------------------
`default_nettype none

package kac_pkg;

  // Key kinds carried on func
  localparam logic [1:0] FUNC_DIGIT  = 2'd0;
  localparam logic [1:0] FUNC_PLUS   = 2'd1;
  localparam logic [1:0] FUNC_EQUALS = 2'd2;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // Segment patterns, bit0 a to bit6 g, active high
  localparam logic [6:0] SEG_E = 7'h79;

  // Four places of segments: index 3 thousands down to index 0 ones
  typedef logic [3:0][6:0] seg_row_t;

  // Four packed BCD digits, thousands in the top nibble
  typedef logic [15:0] bcd4_t;

  typedef struct packed {
    seg_row_t segs;
    logic     error;
    logic     taken;
  } kac_result_t;

  function automatic logic [6:0] seg_of_digit(input logic [3:0] d);
    logic [6:0] p;
    unique case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

  function automatic seg_row_t seg_row(input bcd4_t v);
    seg_row_t r;
    for (int i = 0; i < 4; i++) begin
      r[i] = seg_of_digit(v[4*i +: 4]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/kac_core.sv]
// ----------------------------------------------------------------------------
// kac_core: operand entry, addition and display state
// Operands are held as packed BCD so that entry is a nibble shift and the
// sum needs no binary to decimal conversion; the result is the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module kac_core #(
  parameter int MAX_DIGITS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire logic [1:0]         func,
  input  wire logic [3:0]         digit,
  output kac_pkg::kac_result_t    result
);

  localparam logic [2:0] COUNT_FULL = 3'(MAX_DIGITS);

  kac_pkg::bcd4_t    first_bcd, first_bcd_next;
  kac_pkg::bcd4_t    second_bcd, second_bcd_next;
  logic [2:0]        first_count, first_count_next;
  logic [2:0]        second_count, second_count_next;
  logic              entering_second, entering_second_next;
  logic              second_ready, second_ready_next;
  kac_pkg::seg_row_t shown, shown_next;
  logic              error_shown, error_shown_next;
  logic              taken;

  kac_pkg::bcd4_t    sum_bcd;
  logic              sum_over;

  // Ripple decimal add over four digits; carry out means the sum passed 9999
  function automatic logic [16:0] bcd_add(input kac_pkg::bcd4_t a,
                                          input kac_pkg::bcd4_t b);
    logic [4:0]     s;
    logic           c;
    kac_pkg::bcd4_t r;
    c = 1'b0;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      s = {1'b0, a[4*i +: 4]} + {1'b0, b[4*i +: 4]} + {4'd0, c};
      if (s > 5'd9) begin
        s = s + 5'd6;
        c = 1'b1;
      end else begin
        c = 1'b0;
      end
      r[4*i +: 4] = s[3:0];
    end
    return {c, r};
  endfunction

  assign {sum_over, sum_bcd} = bcd_add(first_bcd, second_bcd);

  always_comb begin
    first_bcd_next       = first_bcd;
    second_bcd_next      = second_bcd;
    first_count_next     = first_count;
    second_count_next    = second_count;
    entering_second_next = entering_second;
    second_ready_next    = second_ready;
    shown_next           = shown;
    error_shown_next     = error_shown;
    taken                = 1'b0;

    unique case (func)
      kac_pkg::FUNC_DIGIT: begin
        if (digit <= kac_pkg::DIGIT_MAX) begin
          if (!entering_second) begin
            if (first_count < COUNT_FULL) begin
              first_bcd_next   = {first_bcd[11:0], digit};
              first_count_next = first_count + 3'd1;
              shown_next       = kac_pkg::seg_row(first_bcd_next);
              error_shown_next = 1'b0;
              taken            = 1'b1;
            end
          end else if (second_count < COUNT_FULL) begin
            second_bcd_next   = {second_bcd[11:0], digit};
            second_count_next = second_count + 3'd1;
            second_ready_next = 1'b1;
            shown_next        = kac_pkg::seg_row(second_bcd_next);
            error_shown_next  = 1'b0;
            taken             = 1'b1;
          end
        end
      end
      kac_pkg::FUNC_PLUS: begin
        if (first_count != 3'd0) begin
          entering_second_next = 1'b1;
          taken                = 1'b1;
        end
      end
      kac_pkg::FUNC_EQUALS: begin
        if (second_ready) begin
          if (sum_over) begin
            shown_next       = {4{kac_pkg::SEG_E}};
            error_shown_next = 1'b1;
          end else begin
            shown_next       = kac_pkg::seg_row(sum_bcd);
            error_shown_next = 1'b0;
          end
          first_bcd_next       = '0;
          second_bcd_next      = '0;
          first_count_next     = 3'd0;
          second_count_next    = 3'd0;
          entering_second_next = 1'b0;
          second_ready_next    = 1'b0;
          taken                = 1'b1;
        end
      end
      default: begin
        // unused key kind: drop
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_bcd       <= '0;
      second_bcd      <= '0;
      first_count     <= 3'd0;
      second_count    <= 3'd0;
      entering_second <= 1'b0;
      second_ready    <= 1'b0;
      shown           <= '0;
      error_shown     <= 1'b0;
    end else if (take) begin
      first_bcd       <= first_bcd_next;
      second_bcd      <= second_bcd_next;
      first_count     <= first_count_next;
      second_count    <= second_count_next;
      entering_second <= entering_second_next;
      second_ready    <= second_ready_next;
      shown           <= shown_next;
      error_shown     <= error_shown_next;
    end
  end

  assign result.segs  = shown_next;
  assign result.error = error_shown_next;
  assign result.taken = taken;

endmodule

`default_nettype wire

[design/kac_out_buf.sv]
// ----------------------------------------------------------------------------
// kac_out_buf: two-entry output buffer
// Registers each result beat and keeps the input side open while one beat
// waits on a stalled receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module kac_out_buf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire kac_pkg::kac_result_t push_data,
  output logic                     space,
  output logic                     head_valid,
  input  wire logic                head_ready,
  output kac_pkg::kac_result_t     head_data
);

  kac_pkg::kac_result_t slot0, slot1;
  logic [1:0]           count;
  logic                 pop;

  assign space      = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = slot0;
  assign pop        = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // payload slots: no reset
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          slot0 <= push_data;
        end else begin
          slot1 <= push_data;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        // one beat held: it leaves, the new one takes the head
        slot0 <= push_data;
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/keypad_adding_calculator.sv]
// ----------------------------------------------------------------------------
// keypad_adding_calculator: four-digit adding calculator on decoded keys
// Takes one key beat (digit, plus or equals) and returns one display beat.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready carry func and digit, one key per beat.
// Output channel: out_valid / out_ready carry the four segment patterns held
// after the key, shows_error and key_taken; exactly one beat per key.
// Throughput: one key per cycle while in_ready is high; the state update is
// a single pass through the digit shift, a four-digit decimal ripple add and
// the segment tables. Each result beat is registered in the output buffer.
// Stall: a two-entry output buffer holds results, so one key more is taken
// while a result waits; in_ready falls only when both entries are full.
// Reset: synchronous, clears both operands, counts and flags, blanks the
// display and empties the output buffer; nothing is emitted for reset.
// MAX_DIGITS (1 to 4) sets how many digits each operand takes.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_adding_calculator #(
  parameter int MAX_DIGITS = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] func,
  input  wire logic [3:0] digit,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      seg_thousands,
  output logic [6:0]      seg_hundreds,
  output logic [6:0]      seg_tens,
  output logic [6:0]      seg_ones,
  output logic            shows_error,
  output logic            key_taken
);

  logic                 take;
  kac_pkg::kac_result_t core_result;
  kac_pkg::kac_result_t head;

  assign take = in_valid && in_ready;

  kac_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .func  (func),
    .digit (digit),
    .result(core_result)
  );

  kac_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (core_result),
    .space     (in_ready),
    .head_valid(out_valid),
    .head_ready(out_ready),
    .head_data (head)
  );

  assign seg_thousands = head.segs[3];
  assign seg_hundreds  = head.segs[2];
  assign seg_tens      = head.segs[1];
  assign seg_ones      = head.segs[0];
  assign shows_error   = head.error;
  assign key_taken     = head.taken;

endmodule

`default_nettype wire

[sim/kac_display_checker.sv]
// ----------------------------------------------------------------------------
// kac_display_checker: display predictor and result checker
// Watches the key and display channels of the keypad adding calculator and
// predicts each display beat from the keys taken. Every display beat is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kac_display_checker #(
  parameter int MAX_DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] func,
  input  logic [3:0] digit,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] seg_thousands,
  input  logic [6:0] seg_hundreds,
  input  logic [6:0] seg_tens,
  input  logic [6:0] seg_ones,
  input  logic       shows_error,
  input  logic       key_taken,
  output int         fail_count,
  output int         beats_due,
  output int         keys_taken,
  output int         sums_shown,
  output int         overflows
);

  localparam int DISPLAY_MAX = 9999;

  logic [13:0]       acc_first;
  logic [13:0]       acc_second;
  logic [2:0]        cnt_first;
  logic [2:0]        cnt_second;
  logic              on_second;
  logic              second_has_digit;
  kac_pkg::seg_row_t shown;
  logic              err_shown;

  kac_pkg::kac_result_t display_due[$];

  initial begin
    fail_count = 0;
    beats_due  = 0;
    keys_taken = 0;
    sums_shown = 0;
    overflows  = 0;
  end

  function automatic logic [6:0] seg_pattern(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      default: p = 7'h6F;
    endcase
    return p;
  endfunction

  // Leading zeros are shown, never blanked
  function automatic void show_number(input int v);
    int x;
    x = v % 10000;
    shown[3]  = seg_pattern(4'((x / 1000) % 10));
    shown[2]  = seg_pattern(4'((x / 100) % 10));
    shown[1]  = seg_pattern(4'((x / 10) % 10));
    shown[0]  = seg_pattern(4'(x % 10));
    err_shown = 1'b0;
  endfunction

  function automatic void press_key(input logic [1:0] f, input logic [3:0] d);
    logic                 taken;
    int                   total;
    kac_pkg::kac_result_t want;
    taken = 1'b0;
    case (f)
      kac_pkg::FUNC_DIGIT: begin
        if (d <= kac_pkg::DIGIT_MAX) begin
          if (!on_second) begin
            if (cnt_first < MAX_DIGITS) begin
              acc_first = 14'(int'(acc_first) * 10 + int'(d));
              cnt_first = cnt_first + 3'd1;
              show_number(int'(acc_first));
              taken = 1'b1;
            end
          end else if (cnt_second < MAX_DIGITS) begin
            acc_second       = 14'(int'(acc_second) * 10 + int'(d));
            cnt_second       = cnt_second + 3'd1;
            second_has_digit = 1'b1;
            show_number(int'(acc_second));
            taken = 1'b1;
          end
        end
      end
      kac_pkg::FUNC_PLUS: begin
        if (cnt_first != 3'd0) begin
          on_second = 1'b1;
          taken     = 1'b1;
        end
      end
      kac_pkg::FUNC_EQUALS: begin
        if (second_has_digit) begin
          total = int'(acc_first) + int'(acc_second);
          if (total > DISPLAY_MAX) begin
            shown     = {4{kac_pkg::SEG_E}};
            err_shown = 1'b1;
            overflows++;
          end else begin
            show_number(total);
          end
          sums_shown++;
          acc_first        = '0;
          acc_second       = '0;
          cnt_first        = '0;
          cnt_second       = '0;
          on_second        = 1'b0;
          second_has_digit = 1'b0;
          taken            = 1'b1;
        end
      end
      default: ;
    endcase
    want.segs  = shown;
    want.error = err_shown;
    want.taken = taken;
    display_due.push_back(want);
    if (taken) keys_taken++;
  endfunction

  task automatic report(input string what, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    kac_pkg::kac_result_t want;
    if (rst) begin
      acc_first        = '0;
      acc_second       = '0;
      cnt_first        = '0;
      cnt_second       = '0;
      on_second        = 1'b0;
      second_has_digit = 1'b0;
      shown            = '0;
      err_shown        = 1'b0;
      display_due.delete();
    end else begin
      // Retire the display beat first, then predict the key taken at this edge
      if (out_valid && out_ready) begin
        if (display_due.size() == 0) begin
          $display("%0t: display beat with nothing expected, actual %h %h %h %h err %b taken %b",
                   $time, seg_thousands, seg_hundreds, seg_tens, seg_ones,
                   shows_error, key_taken);
          fail_count++;
        end else begin
          want = display_due.pop_front();
          if (seg_thousands !== want.segs[3]) report("seg_thousands", want.segs[3], seg_thousands);
          if (seg_hundreds !== want.segs[2])  report("seg_hundreds", want.segs[2], seg_hundreds);
          if (seg_tens !== want.segs[1])      report("seg_tens", want.segs[1], seg_tens);
          if (seg_ones !== want.segs[0])      report("seg_ones", want.segs[0], seg_ones);
          if (shows_error !== want.error)     report("shows_error", want.error, shows_error);
          if (key_taken !== want.taken)       report("key_taken", want.taken, key_taken);
        end
      end
      if (in_valid && in_ready) press_key(func, digit);
    end
    beats_due = display_due.size();
  end

endmodule

[sim/tb_keypad_adding_calculator.sv]
// ----------------------------------------------------------------------------
// tb_keypad_adding_calculator: testbench of the keypad adding calculator
// Presses a directed run of keys covering early, full and overflow cases,
// then random sums and stray keys, with random gaps and display stalls.
// The checker beside the core predicts and compares every display beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keypad_adding_calculator;

  localparam int KEY_DIGITS  = 4;
  localparam int KEYS_WANTED = 1950;
  localparam int CALM_AFTER  = 1750;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] func;
  logic [3:0] digit;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] seg_thousands;
  logic [6:0] seg_hundreds;
  logic [6:0] seg_tens;
  logic [6:0] seg_ones;
  logic       shows_error;
  logic       key_taken;

  int fail_count;
  int beats_due;
  int keys_taken;
  int sums_shown;
  int overflows;
  int keys_sent;

  logic in_idle;
  logic stall_out;

  always #10 clk = ~clk;

  keypad_adding_calculator #(.MAX_DIGITS(KEY_DIGITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .digit(digit),
    .out_valid(out_valid), .out_ready(out_ready),
    .seg_thousands(seg_thousands), .seg_hundreds(seg_hundreds),
    .seg_tens(seg_tens), .seg_ones(seg_ones),
    .shows_error(shows_error), .key_taken(key_taken)
  );

  kac_display_checker #(.MAX_DIGITS(KEY_DIGITS)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .digit(digit),
    .out_valid(out_valid), .out_ready(out_ready),
    .seg_thousands(seg_thousands), .seg_hundreds(seg_hundreds),
    .seg_tens(seg_tens), .seg_ones(seg_ones),
    .shows_error(shows_error), .key_taken(key_taken),
    .fail_count(fail_count), .beats_due(beats_due), .keys_taken(keys_taken),
    .sums_shown(sums_shown), .overflows(overflows)
  );

  // Display side: hold ready low in random bursts while stalls are enabled
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_out && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_key(input logic [1:0] f, input logic [3:0] d);
    if (in_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    digit    <= d;
    do @(posedge clk); while (!in_ready);
    keys_sent++;
  endtask

  // Lean towards nines so that sums reach the overflow boundary often
  function automatic logic [3:0] pick_digit();
    if ($urandom_range(0, 3) == 0) return 4'd9;
    return 4'($urandom_range(0, 9));
  endfunction

  task automatic run_sum();
    int n_first;
    int n_second;
    n_first  = ($urandom_range(0, 9) == 0) ? KEY_DIGITS + 1 : $urandom_range(1, KEY_DIGITS);
    n_second = ($urandom_range(0, 9) == 0) ? KEY_DIGITS + 1 : $urandom_range(1, KEY_DIGITS);
    repeat (n_first) send_key(kac_pkg::FUNC_DIGIT, pick_digit());
    if ($urandom_range(0, 9) == 0) send_key(kac_pkg::FUNC_DIGIT, 4'($urandom_range(10, 15)));
    send_key(kac_pkg::FUNC_PLUS, 4'($urandom_range(0, 15)));
    if ($urandom_range(0, 4) == 0) send_key(kac_pkg::FUNC_PLUS, 4'($urandom_range(0, 15)));
    repeat (n_second) send_key(kac_pkg::FUNC_DIGIT, pick_digit());
    send_key(kac_pkg::FUNC_EQUALS, 4'($urandom_range(0, 15)));
    if ($urandom_range(0, 7) == 0) send_key(kac_pkg::FUNC_EQUALS, 4'($urandom_range(0, 15)));
  endtask

  task automatic stray_keys();
    repeat ($urandom_range(1, 6)) send_key(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
  endtask

  initial begin
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    func      = kac_pkg::FUNC_DIGIT;
    digit     = 4'd0;
    in_idle   = 1'b0;
    stall_out = 1'b0;
    keys_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Early keys on a blank display, then odd key codes
    send_key(kac_pkg::FUNC_EQUALS, 4'd0);
    send_key(kac_pkg::FUNC_PLUS, 4'd15);
    send_key(2'd3, 4'd5);
    send_key(kac_pkg::FUNC_DIGIT, 4'd12);
    // Fill the first operand, overrun it, then overflow the sum
    repeat (4) send_key(kac_pkg::FUNC_DIGIT, 4'd9);
    send_key(kac_pkg::FUNC_DIGIT, 4'd9);
    send_key(kac_pkg::FUNC_PLUS, 4'd0);
    send_key(kac_pkg::FUNC_PLUS, 4'd0);
    send_key(kac_pkg::FUNC_EQUALS, 4'd15);
    send_key(kac_pkg::FUNC_DIGIT, 4'd1);
    send_key(kac_pkg::FUNC_EQUALS, 4'd0);
    // Zero plus zero clears the error
    send_key(kac_pkg::FUNC_DIGIT, 4'd0);
    send_key(kac_pkg::FUNC_PLUS, 4'd0);
    send_key(kac_pkg::FUNC_DIGIT, 4'd0);
    send_key(kac_pkg::FUNC_EQUALS, 4'd0);
    // Largest sum that still fits
    send_key(kac_pkg::FUNC_DIGIT, 4'd9);
    send_key(kac_pkg::FUNC_DIGIT, 4'd9);
    send_key(kac_pkg::FUNC_DIGIT, 4'd9);
    send_key(kac_pkg::FUNC_DIGIT, 4'd8);
    send_key(kac_pkg::FUNC_PLUS, 4'd0);
    send_key(kac_pkg::FUNC_DIGIT, 4'd1);
    send_key(kac_pkg::FUNC_EQUALS, 4'd0);

    while (keys_sent < KEYS_WANTED) begin
      in_idle   = (keys_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      stall_out = (keys_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) stray_keys();
      else run_sum();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (beats_due == 0);
    repeat (8) @(posedge clk);

    $display("Pressed %0d keys, %0d taken by the calculator.", keys_sent, keys_taken);
    $display("Completed %0d sums, %0d of them overflowed to E.", sums_shown, overflows);
    if (fail_count == 0 && beats_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
